// ===== sv/gum_pkg.sv =====
// ----------------------------------------------------------------------------
// gum_pkg: shared types and constants of the unsharp mask block
// Payload structures, configuration register indexes and reset values,
// arithmetic widths and the command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package gum_pkg;

   localparam int PIXEL_W       = 8;
   localparam int WEIGHT_W      = 16;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 12;
   localparam int MODE_W        = 2;
   localparam int ROW_W         = HEIGHT_REG_W + 1;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DIV_CNT_W     = $clog2(PIXEL_W);
   localparam int SHARP_FRAC    = 12;

   localparam int P_W     = WEIGHT_W + PIXEL_W;
   localparam int Q_W     = WEIGHT_W + PIXEL_W + 1;
   localparam int R_W     = WEIGHT_W + PIXEL_W + 2;
   localparam int NC_W    = 2 * WEIGHT_W + PIXEL_W + 2;
   localparam int NS_W    = 2 * WEIGHT_W + PIXEL_W + 3;
   localparam int NUM_W   = 2 * WEIGHT_W + PIXEL_W + 4;
   localparam int WSUM_W  = WEIGHT_W + 2;
   localparam int DEN_W   = 2 * WEIGHT_W + 4;
   localparam int DIFF_W  = PIXEL_W + 1;
   localparam int PROD_W  = WEIGHT_W + PIXEL_W + 2;
   localparam int TOT_W   = WEIGHT_W + PIXEL_W + 3;

   localparam logic [PIXEL_W-1:0] PIXEL_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER_MODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_CENTER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VERT_SIDE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_CENTER = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HORIZ_SIDE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SHARPEN      = 3'd7;

   localparam logic [MODE_W-1:0] MODE_ZERO       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIRROR     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RENORM     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MIRROR_ALT = 2'd3;

   localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 11'd512;
   localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 12'd512;
   localparam logic [MODE_W-1:0]       RST_BORDER_MODE  = MODE_MIRROR;
   localparam logic [WEIGHT_W-1:0]     RST_CENTER       = 16'd29614;
   localparam logic [WEIGHT_W-1:0]     RST_SIDE         = 16'd17961;
   localparam logic [WEIGHT_W-1:0]     RST_SHARPEN      = 16'd4096;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_in;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               row_end;
      logic               frame_end;
   } rsp_type;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0]  image_width;
      logic [HEIGHT_REG_W-1:0] image_height;
      logic [MODE_W-1:0]       border_mode;
      logic [WEIGHT_W-1:0]     vert_center_weight;
      logic [WEIGHT_W-1:0]     vert_side_weight;
      logic [WEIGHT_W-1:0]     horiz_center_weight;
      logic [WEIGHT_W-1:0]     horiz_side_weight;
      logic [WEIGHT_W-1:0]     sharpen_amount;
   } cfg_type;

   typedef struct packed {
      logic                 pix_load;
      logic                 pix_zero;
      logic                 ram_rd;
      logic                 shift;
      logic                 top_valid;
      logic                 mid_valid;
      logic                 kern_load;
      logic                 edge_pix;
      logic                 top_out;
      logic                 bot_out;
      logic                 left_out;
      logic                 right_out;
      logic                 step_prod;
      logic                 step_rowsum;
      logic                 step_scale;
      logic                 step_accum;
      logic                 step_div;
      logic [DIV_CNT_W-1:0] div_bit;
      logic                 step_final;
      logic                 out_load;
      logic                 row_end;
      logic                 frame_end;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== sv/gum_ram.sv =====
// ----------------------------------------------------------------------------
// gum_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gum_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/gum_ctrl.sv =====
// ----------------------------------------------------------------------------
// gum_ctrl: sequencing controller of the unsharp mask block
// Tracks the raster position, decides which result each pixel produces and
// steps the datapath through line store access, blur and sharpening.
// ----------------------------------------------------------------------------
module gum_ctrl #(
   parameter int MAX_WIDTH = gum_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         frame_start,
   input  gum_pkg::cfg_type             cfg,
   input  gum_pkg::status_type          status,
   output gum_pkg::cmd_type             cmd,
   output logic [$clog2(MAX_WIDTH)-1:0] ram_addr
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > gum_pkg::WIDTH_REG_W) ? CW + 1 : gum_pkg::WIDTH_REG_W;
   localparam int RW = gum_pkg::ROW_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_PROD, ST_ROWSUM, ST_SCALE, ST_ACCUM, ST_DIV, ST_FINAL, ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     col_ff, col_in, ic_ff, ic_in;
   logic [RW-1:0]                     row_ff, row_in;
   logic                              active_ff, active_in;
   logic                              do_shift_ff, do_shift_in, do_result_ff, do_result_in;
   logic                              edge_ff, edge_in, top_valid_ff, top_valid_in;
   logic                              mid_valid_ff, mid_valid_in;
   logic                              top_out_ff, top_out_in, bot_out_ff, bot_out_in;
   logic                              left_out_ff, left_out_in;
   logic                              frame_end_ff, frame_end_in;
   logic [gum_pkg::DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;

   logic [WW-1:0]                     w_eff, col0, ic_plus;
   logic [gum_pkg::HEIGHT_REG_W-1:0]  h_eff;
   logic [RW-1:0]                     row0, ir, h_plus;
   logic [CW-1:0]                     ic;
   logic                              act0, wrap, gone, last, edge_pix, normal, accept;

   always_comb begin
      if (WW'(cfg.image_width) < WW'(2)) begin
         w_eff = WW'(2);
      end else if (WW'(cfg.image_width) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg.image_width);
      end
      h_eff = (cfg.image_height < gum_pkg::HEIGHT_REG_W'(2)) ?
              gum_pkg::HEIGHT_REG_W'(2) : cfg.image_height;
      h_plus = RW'(h_eff) + RW'(1);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      act0     = frame_start || active_ff;
      col0     = frame_start ? '0 : WW'(col_ff);
      row0     = frame_start ? '0 : row_ff;
      wrap     = col0 >= w_eff;
      ic       = wrap ? '0 : col0[CW-1:0];
      ir       = wrap ? row0 + RW'(1) : row0;
      gone     = ir > h_plus;
      last     = ir == h_plus;
      edge_pix = (ic == '0) && (ir >= RW'(2));
      normal   = !last && (ic != '0) && (ir != '0);
      ic_plus  = WW'(ic) + WW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      active_in    = active_ff;
      ic_in        = ic_ff;
      do_shift_in  = do_shift_ff;
      do_result_in = do_result_ff;
      edge_in      = edge_ff;
      top_valid_in = top_valid_ff;
      mid_valid_in = mid_valid_ff;
      top_out_in   = top_out_ff;
      bot_out_in   = bot_out_ff;
      left_out_in  = left_out_ff;
      frame_end_in = frame_end_ff;
      div_cnt_in   = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && act0) begin
               active_in = !gone && !last;
               if (ic_plus >= w_eff) begin
                  col_in = '0;
                  row_in = ir + RW'(1);
               end else begin
                  col_in = ic_plus[CW-1:0];
                  row_in = ir;
               end
               ic_in        = ic;
               do_shift_in  = !last;
               do_result_in = edge_pix || normal;
               edge_in      = edge_pix;
               top_valid_in = ir >= RW'(2);
               mid_valid_in = ir >= RW'(1);
               top_out_in   = edge_pix ? (ir == RW'(2)) : (ir == RW'(1));
               bot_out_in   = edge_pix ? (ir >= h_plus) : (ir >= RW'(h_eff));
               left_out_in  = !edge_pix && (ic == CW'(1));
               frame_end_in = edge_pix && last;
               if (!gone) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD:   state_in = do_result_ff ? ST_PROD : ST_IDLE;
         ST_PROD:   state_in = ST_ROWSUM;
         ST_ROWSUM: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (cfg.border_mode == gum_pkg::MODE_RENORM) begin
               div_cnt_in = gum_pkg::DIV_CNT_W'(gum_pkg::PIXEL_W - 1);
               state_in   = ST_DIV;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = ST_FINAL;
            end else begin
               div_cnt_in = div_cnt_ff - gum_pkg::DIV_CNT_W'(1);
            end
         end
         ST_FINAL: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         active_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         active_ff <= active_in;
      end
      ic_ff        <= ic_in;
      do_shift_ff  <= do_shift_in;
      do_result_ff <= do_result_in;
      edge_ff      <= edge_in;
      top_valid_ff <= top_valid_in;
      mid_valid_ff <= mid_valid_in;
      top_out_ff   <= top_out_in;
      bot_out_ff   <= bot_out_in;
      left_out_ff  <= left_out_in;
      frame_end_ff <= frame_end_in;
      div_cnt_ff   <= div_cnt_in;
   end

   assign ram_addr = (state_ff == ST_IDLE) ? ic : ic_ff;

   always_comb begin
      cmd             = '0;
      cmd.pix_load    = accept;
      cmd.pix_zero    = ir >= RW'(h_eff);
      cmd.ram_rd      = accept;
      cmd.shift       = (state_ff == ST_LOAD) && do_shift_ff;
      cmd.kern_load   = (state_ff == ST_LOAD) && do_result_ff;
      cmd.top_valid   = top_valid_ff;
      cmd.mid_valid   = mid_valid_ff;
      cmd.edge_pix    = edge_ff;
      cmd.top_out     = top_out_ff;
      cmd.bot_out     = bot_out_ff;
      cmd.left_out    = left_out_ff;
      cmd.right_out   = edge_ff;
      cmd.step_prod   = state_ff == ST_PROD;
      cmd.step_rowsum = state_ff == ST_ROWSUM;
      cmd.step_scale  = state_ff == ST_SCALE;
      cmd.step_accum  = state_ff == ST_ACCUM;
      cmd.step_div    = state_ff == ST_DIV;
      cmd.div_bit     = div_cnt_ff;
      cmd.step_final  = state_ff == ST_FINAL;
      cmd.out_load    = (state_ff == ST_EMIT) && status.out_free;
      cmd.row_end     = edge_ff;
      cmd.frame_end   = frame_end_ff;
   end

endmodule

// ===== sv/gum_dp.sv =====
// ----------------------------------------------------------------------------
// gum_dp: datapath of the unsharp mask block
// Line stores, 3x3 window, separable Gaussian blur with border handling,
// restoring divider for renormalisation, sharpening and the output register.
// ----------------------------------------------------------------------------
module gum_dp #(
   parameter int MAX_WIDTH = gum_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gum_pkg::cfg_type             cfg,
   input  gum_pkg::cmd_type             cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0] ram_addr,
   input  logic [gum_pkg::PIXEL_W-1:0]  pixel_in,
   output gum_pkg::status_type          status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gum_pkg::rsp_type             rsp_payload
);

   localparam int P  = gum_pkg::PIXEL_W;
   localparam int W  = gum_pkg::WEIGHT_W;
   localparam int AW = $clog2(MAX_WIDTH);

   logic [P-1:0]                   px_ff;
   logic [P-1:0]                   up_rdata, lo_rdata, top_v, mid_v;
   logic [P-1:0]                   win_ff [3][3];
   logic [P-1:0]                   win_in [3][3];
   logic [P-1:0]                   kern_ff [3][3];
   logic [P-1:0]                   kern_in [3][3];
   logic [P-1:0]                   gsel [3][3];
   logic [gum_pkg::P_W-1:0]        p_ff [3];
   logic [gum_pkg::Q_W-1:0]        q_ff [3];
   logic [gum_pkg::R_W-1:0]        r_ff [3];
   logic [gum_pkg::WSUM_W-1:0]     vsum_ff, hsum_ff;
   logic [gum_pkg::NC_W-1:0]       nc_ff;
   logic [gum_pkg::NS_W-1:0]       ns_ff;
   logic [gum_pkg::DEN_W-1:0]      den_ff;
   logic [gum_pkg::NUM_W-1:0]      rem_ff, den_shift;
   logic [P-1:0]                   quo_ff;
   logic [P-1:0]                   blur, pc;
   logic [gum_pkg::NUM_W-2*W-1:0]  blur_hi;
   logic signed [gum_pkg::DIFF_W-1:0] diff;
   logic signed [gum_pkg::PROD_W-1:0] prod_ff;
   logic signed [gum_pkg::TOT_W-1:0]  total;
   logic [gum_pkg::TOT_W-2-gum_pkg::SHARP_FRAC:0] total_int;
   logic [P-1:0]                   sharp;
   logic                           mirror, renorm;
   logic                           row_out [3];
   logic                           col_out [3];
   logic                           rsp_valid_ff;
   gum_pkg::rsp_type               rsp_ff;

   gum_ram #(.DATA_W(P), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock (clock),
      .we    (cmd.shift),
      .waddr (ram_addr),
      .wdata (mid_v),
      .re    (cmd.ram_rd),
      .raddr (ram_addr),
      .rdata (up_rdata)
   );

   gum_ram #(.DATA_W(P), .DEPTH(MAX_WIDTH)) u_line_lower (
      .clock (clock),
      .we    (cmd.shift),
      .waddr (ram_addr),
      .wdata (px_ff),
      .re    (cmd.ram_rd),
      .raddr (ram_addr),
      .rdata (lo_rdata)
   );

   assign top_v  = cmd.top_valid ? up_rdata : '0;
   assign mid_v  = cmd.mid_valid ? lo_rdata : '0;
   assign mirror = (cfg.border_mode == gum_pkg::MODE_MIRROR) ||
                   (cfg.border_mode == gum_pkg::MODE_MIRROR_ALT);
   assign renorm = cfg.border_mode == gum_pkg::MODE_RENORM;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][1];
         win_in[r][1] = win_ff[r][2];
      end
      win_in[0][2] = top_v;
      win_in[1][2] = mid_v;
      win_in[2][2] = px_ff;
      for (int r = 0; r < 3; r++) begin
         if (cmd.edge_pix) begin
            kern_in[r][0] = win_ff[r][1];
            kern_in[r][1] = win_ff[r][2];
            kern_in[r][2] = '0;
         end else begin
            for (int c = 0; c < 3; c++) begin
               kern_in[r][c] = win_in[r][c];
            end
         end
      end
   end

   always_comb begin
      int ra;
      int cb;
      row_out[0] = cmd.top_out;
      row_out[1] = 1'b0;
      row_out[2] = cmd.bot_out;
      col_out[0] = cmd.left_out;
      col_out[1] = 1'b0;
      col_out[2] = cmd.right_out;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            ra = row_out[a] ? 2 - a : a;
            cb = col_out[b] ? 2 - b : b;
            if (mirror) begin
               gsel[a][b] = kern_ff[ra][cb];
            end else if (row_out[a] || col_out[b]) begin
               gsel[a][b] = '0;
            end else begin
               gsel[a][b] = kern_ff[a][b];
            end
         end
      end
   end

   assign den_shift = gum_pkg::NUM_W'(den_ff) << cmd.div_bit;
   assign blur_hi   = rem_ff[gum_pkg::NUM_W-1:2*W];
   assign pc        = kern_ff[1][1];

   always_comb begin
      if (renorm) begin
         blur = (den_ff == '0) ? '0 : quo_ff;
      end else if (blur_hi > (gum_pkg::NUM_W-2*W)'(gum_pkg::PIXEL_MAX)) begin
         blur = gum_pkg::PIXEL_MAX;
      end else begin
         blur = blur_hi[P-1:0];
      end
      diff      = $signed({1'b0, pc}) - $signed({1'b0, blur});
      total     = $signed({{(gum_pkg::TOT_W-P-gum_pkg::SHARP_FRAC){1'b0}}, pc,
                           {gum_pkg::SHARP_FRAC{1'b0}}}) + gum_pkg::TOT_W'(prod_ff);
      total_int = total[gum_pkg::TOT_W-2:gum_pkg::SHARP_FRAC];
      if (total[gum_pkg::TOT_W-1]) begin
         sharp = '0;
      end else if (total_int > ($bits(total_int))'(gum_pkg::PIXEL_MAX)) begin
         sharp = gum_pkg::PIXEL_MAX;
      end else begin
         sharp = total_int[P-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         px_ff <= cmd.pix_zero ? '0 : pixel_in;
      end
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.shift) begin
         win_ff <= win_in;
      end
      if (cmd.kern_load) begin
         kern_ff <= kern_in;
      end
      if (cmd.step_prod) begin
         for (int a = 0; a < 3; a++) begin
            p_ff[a] <= gum_pkg::P_W'(cfg.horiz_center_weight) * gum_pkg::P_W'(gsel[a][1]);
            q_ff[a] <= gum_pkg::Q_W'(cfg.horiz_side_weight) *
                       (gum_pkg::Q_W'(gsel[a][0]) + gum_pkg::Q_W'(gsel[a][2]));
         end
         vsum_ff <= gum_pkg::WSUM_W'(cfg.vert_center_weight) +
                    (cmd.top_out ? '0 : gum_pkg::WSUM_W'(cfg.vert_side_weight)) +
                    (cmd.bot_out ? '0 : gum_pkg::WSUM_W'(cfg.vert_side_weight));
         hsum_ff <= gum_pkg::WSUM_W'(cfg.horiz_center_weight) +
                    (cmd.left_out ? '0 : gum_pkg::WSUM_W'(cfg.horiz_side_weight)) +
                    (cmd.right_out ? '0 : gum_pkg::WSUM_W'(cfg.horiz_side_weight));
      end
      if (cmd.step_rowsum) begin
         for (int a = 0; a < 3; a++) begin
            r_ff[a] <= gum_pkg::R_W'(p_ff[a]) + gum_pkg::R_W'(q_ff[a]);
         end
      end
      if (cmd.step_scale) begin
         nc_ff  <= gum_pkg::NC_W'(cfg.vert_center_weight) * gum_pkg::NC_W'(r_ff[1]);
         ns_ff  <= gum_pkg::NS_W'(cfg.vert_side_weight) *
                   (gum_pkg::NS_W'(r_ff[0]) + gum_pkg::NS_W'(r_ff[2]));
         den_ff <= gum_pkg::DEN_W'(vsum_ff) * gum_pkg::DEN_W'(hsum_ff);
      end
      if (cmd.step_accum) begin
         rem_ff <= gum_pkg::NUM_W'(nc_ff) + gum_pkg::NUM_W'(ns_ff);
         quo_ff <= '0;
      end else if (cmd.step_div) begin
         if (rem_ff >= den_shift) begin
            rem_ff               <= rem_ff - den_shift;
            quo_ff[cmd.div_bit]  <= 1'b1;
         end
      end
      if (cmd.step_final) begin
         prod_ff <= $signed({1'b0, cfg.sharpen_amount}) * diff;
      end
      if (cmd.out_load) begin
         rsp_ff.pixel_out <= sharp;
         rsp_ff.row_end   <= cmd.row_end;
         rsp_ff.frame_end <= cmd.frame_end;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

// ===== sv/gaussian_unsharp_mask_3x3.sv =====
// ----------------------------------------------------------------------------
// gaussian_unsharp_mask_3x3: streaming 3x3 Gaussian unsharp mask
// Sharpens 8-bit grey pixels in raster order against a separable blur.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel, one transaction per pixel, with
// frame_start marking the first pixel of a frame. Each frame needs its
// width plus one extra flush transactions after the last pixel to drain.
// Sharpened pixels leave on the rsp_ channel with row and frame end flags;
// the result for pixel (r,c) follows the transaction at (r+1,c+1), and the
// last pixel of a row follows the first transaction two rows on.
// Each pixel takes one pass of a shared sequencer, with req_stall high until
// it ends. A transaction with no result only loads the window; one with a
// result then runs product, row sum, scale, accumulate, final and emit, with
// an 8-step restoring divider after accumulate when renormalising. A finished
// result waits in an output register, so the next pixel is taken while the
// receiver stalls; emit only holds when a second result is ready before the
// first is gone. Registers are written on the csr_ port; the user must do so
// only while idle (the block does not enforce it); csr_ready is always high.
// Synchronous reset restores register defaults, empties the output register,
// clears the window and starts a frame at row 0, column 0. No clearing pass.
// ----------------------------------------------------------------------------
module gaussian_unsharp_mask_3x3 #(
   parameter int MAX_WIDTH = gum_pkg::DEF_MAX_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gum_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gum_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gum_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gum_pkg::CSR_DATA_W-1:0]  csr_data
);

   gum_pkg::cfg_type             cfg_ff;
   gum_pkg::cmd_type             cmd;
   gum_pkg::status_type          status;
   logic [$clog2(MAX_WIDTH)-1:0] ram_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width         <= gum_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height        <= gum_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.border_mode         <= gum_pkg::RST_BORDER_MODE;
         cfg_ff.vert_center_weight  <= gum_pkg::RST_CENTER;
         cfg_ff.vert_side_weight    <= gum_pkg::RST_SIDE;
         cfg_ff.horiz_center_weight <= gum_pkg::RST_CENTER;
         cfg_ff.horiz_side_weight   <= gum_pkg::RST_SIDE;
         cfg_ff.sharpen_amount      <= gum_pkg::RST_SHARPEN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gum_pkg::REG_IMAGE_WIDTH:
               cfg_ff.image_width <= csr_data[gum_pkg::WIDTH_REG_W-1:0];
            gum_pkg::REG_IMAGE_HEIGHT:
               cfg_ff.image_height <= csr_data[gum_pkg::HEIGHT_REG_W-1:0];
            gum_pkg::REG_BORDER_MODE:
               cfg_ff.border_mode <= csr_data[gum_pkg::MODE_W-1:0];
            gum_pkg::REG_VERT_CENTER:  cfg_ff.vert_center_weight  <= csr_data;
            gum_pkg::REG_VERT_SIDE:    cfg_ff.vert_side_weight    <= csr_data;
            gum_pkg::REG_HORIZ_CENTER: cfg_ff.horiz_center_weight <= csr_data;
            gum_pkg::REG_HORIZ_SIDE:   cfg_ff.horiz_side_weight   <= csr_data;
            gum_pkg::REG_SHARPEN:      cfg_ff.sharpen_amount      <= csr_data;
            default: ;
         endcase
      end
   end

   gum_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .frame_start (req_payload.frame_start),
      .cfg         (cfg_ff),
      .status      (status),
      .cmd         (cmd),
      .ram_addr    (ram_addr)
   );

   gum_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .ram_addr    (ram_addr),
      .pixel_in    (req_payload.pixel_in),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("Result loaded over a transaction still waiting.");

   a_busy_while_working: assert property (@(posedge clock) disable iff (reset)
      (cmd.shift || cmd.step_prod || cmd.step_div) |-> req_stall)
      else $error("Input open while the datapath is working.");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("Result appeared without a load.");
`endif

endmodule
